[src/nrp_pkg.sv]
// shared types and constants of the nernst reversal potential block
package nrp_pkg;

    // result kind codes
    typedef enum logic [1:0] {
        KIND_NORMAL = 2'd0,
        KIND_ZERO_Z = 2'd1,
        KIND_IN_NP  = 2'd2,
        KIND_OUT_NP = 2'd3
    } t_kind;

    // log2 result: 5 integer bits, 24 fraction bits
    localparam int FRAC_W = 24;
    localparam int LOG_W  = 29;
    localparam int STEPS  = FRAC_W;

    // quotient width before the small divide
    localparam int Y_W = 19;

    // 2^40 * 1000*8.3134*ln2 / (5*96485.309)
    localparam logic [33:0] KCOEF = 34'd13133266842;
    // 273.15 kelvin in 1/1280 K
    localparam logic signed [20:0] TK5_OFFSET = 21'sd349632;
    // +-1e6 mV with 8 fraction bits
    localparam logic signed [28:0] POT_LIMIT = 29'sd256000000;

    // start transfer to result transfer, in clock edges
    localparam int TOTAL_LAT = 33;

    // sideband that travels with an item
    typedef struct packed {
        t_kind      kind;
        logic       neg;
        logic [4:0] zmag;
    } t_side;

endpackage

[src/nernst_reversal_potential.sv]
// top level of the nernst reversal potential pipeline
//
// Usage: drive i_conc_inside, i_conc_outside (signed Q16.16 mM) and
// i_valence with start high; the item transfers at that edge when busy
// is low. busy is always low: a new item may enter every cycle.
// Each result shows on o_potential (signed mV, 8 fraction bits) and
// o_kind for exactly one cycle with o_strobe high; o_strobe and the result
// are registered behind the divide and the sign and special case select.
// Throughput is one item per cycle; the depth is set by
// the 24 squaring stages of the two log2 lanes plus the scale multiply
// and the three stage divide by the valence.
// The temperature register is written through i_cfg_valid/i_cfg_data;
// o_cfg_ready is always high. Write it only while no item is in flight;
// the scale factor passes through r_tk5 into r_a after the write.
// Reset clears all valid bits and sets the temperature to 1613 (6.3 degC).
// The receiver cannot stall; results are never held back.
module nernst_reversal_potential (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_conc_inside,
    input  logic signed [31:0] i_conc_outside,
    input  logic signed [4:0]  i_valence,
    output logic               o_strobe,
    output logic signed [28:0] o_potential,
    output logic [1:0]         o_kind,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic signed [15:0] i_cfg_data
);
    import nrp_pkg::*;

    // configuration and scale factor
    logic signed [15:0] r_temperature;
    logic [18:0]        r_tk5;
    logic [28:0]        r_a;
    logic signed [20:0] tsx;
    logic signed [20:0] tk5_full;
    logic [52:0]        a_prod;

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temperature <= 16'sd1613;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_temperature <= i_cfg_data;
        end
    end

    assign tsx      = 21'(r_temperature);
    assign tk5_full = (tsx <<< 2) + tsx + TK5_OFFSET;
    assign a_prod   = {19'b0, KCOEF} * {34'b0, r_tk5};

    always_ff @(posedge i_clk) begin
        r_tk5 <= tk5_full[18:0];
        r_a   <= a_prod[52:24];
    end

    // input register
    logic               r_in_vld;
    logic signed [31:0] r_in_ci;
    logic signed [31:0] r_in_co;
    logic signed [4:0]  r_in_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= start && !busy;
        end
        r_in_ci <= i_conc_inside;
        r_in_co <= i_conc_outside;
        r_in_z  <= i_valence;
    end

    // classify the item
    t_side n_side;
    always_comb begin
        if (r_in_z == 5'sd0) begin
            n_side.kind = KIND_ZERO_Z;
        end else if (r_in_ci <= 32'sd0) begin
            n_side.kind = KIND_IN_NP;
        end else if (r_in_co <= 32'sd0) begin
            n_side.kind = KIND_OUT_NP;
        end else begin
            n_side.kind = KIND_NORMAL;
        end
        n_side.neg  = r_in_z[4];
        n_side.zmag = r_in_z[4] ? 5'(-r_in_z) : r_in_z;
    end

    // log2 lanes
    logic [LOG_W-1:0] log_ci;
    logic [LOG_W-1:0] log_co;

    nrp_log2 u_log_ci (.i_clk(i_clk), .i_x(r_in_ci[30:0]), .o_log(log_ci));
    nrp_log2 u_log_co (.i_clk(i_clk), .i_x(r_in_co[30:0]), .o_log(log_co));

    // sideband shift line matching the log stages
    logic  r_sb_vld [0:STEPS];
    t_side r_sb     [0:STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= STEPS; k++) begin
                r_sb_vld[k] <= 1'b0;
            end
        end else begin
            r_sb_vld[0] <= r_in_vld;
            for (int k = 1; k <= STEPS; k++) begin
                r_sb_vld[k] <= r_sb_vld[k-1];
            end
        end
        r_sb[0] <= n_side;
        for (int k = 1; k <= STEPS; k++) begin
            r_sb[k] <= r_sb[k-1];
        end
    end

    // log difference and its magnitude
    logic [29:0]      ldiff;
    t_side            n_d_side;
    logic             r_d_vld;
    t_side            r_d_side;
    logic [LOG_W-1:0] r_d_lmag;

    assign ldiff = {1'b0, log_co} - {1'b0, log_ci};

    // result sign from the valence sign and the log difference sign
    always_comb begin
        n_d_side     = r_sb[STEPS];
        n_d_side.neg = r_sb[STEPS].neg ^ ldiff[29];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else begin
            r_d_vld <= r_sb_vld[STEPS];
        end
        r_d_side <= n_d_side;
        r_d_lmag <= ldiff[29] ? 29'(-ldiff) : ldiff[28:0];
    end

    // scale by the temperature factor
    logic        r_e_vld;
    t_side       r_e_side;
    logic [57:0] r_e_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else begin
            r_e_vld <= r_d_vld;
        end
        r_e_side <= r_d_side;
        r_e_prod <= {29'b0, r_a} * {29'b0, r_d_lmag};
    end

    // add half of the divisor and drop the 2^40 scale
    logic [59:0]    ysum;
    logic           r_f_vld;
    t_side          r_f_side;
    logic [Y_W-1:0] r_f_y;

    assign ysum = {2'b0, r_e_prod} + (60'(r_e_side.zmag) << 39);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else begin
            r_f_vld <= r_e_vld;
        end
        r_f_side <= r_e_side;
        r_f_y    <= ysum[58:40];
    end

    // divide by the valence magnitude
    localparam int DIV_LAT = 3;
    logic [Y_W-1:0] div_q;
    logic           r_dv_vld  [0:DIV_LAT-1];
    t_side          r_dv_side [0:DIV_LAT-1];

    nrp_divz u_divz (.i_clk(i_clk), .i_y(r_f_y), .i_zmag(r_f_side.zmag), .o_q(div_q));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_LAT; k++) begin
                r_dv_vld[k] <= 1'b0;
            end
        end else begin
            r_dv_vld[0] <= r_f_vld;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_dv_vld[k] <= r_dv_vld[k-1];
            end
        end
        r_dv_side[0] <= r_f_side;
        for (int k = 1; k < DIV_LAT; k++) begin
            r_dv_side[k] <= r_dv_side[k-1];
        end
    end

    // apply sign and special cases
    t_side              last_side;
    logic signed [28:0] n_pot;
    logic [28:0]        qext;
    logic               r_strobe;
    logic signed [28:0] r_pot;
    t_kind              r_kind;

    assign last_side = r_dv_side[DIV_LAT-1];
    assign qext      = {10'b0, div_q};

    always_comb begin
        case (last_side.kind)
            KIND_NORMAL: n_pot = last_side.neg ? -signed'(qext) : signed'(qext);
            KIND_ZERO_Z: n_pot = '0;
            KIND_IN_NP:  n_pot = POT_LIMIT;
            KIND_OUT_NP: n_pot = -POT_LIMIT;
            default:     n_pot = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_dv_vld[DIV_LAT-1];
        end
        r_pot  <= n_pot;
        r_kind <= last_side.kind;
    end

    assign o_strobe    = r_strobe;
    assign o_potential = r_pot;
    assign o_kind      = r_kind;

    // every transfer yields one strobe after the fixed latency
    a_lat_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##TOTAL_LAT o_strobe)
        else $error("result missing after input transfer");

    a_lat_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy && i_rst_n, TOTAL_LAT))
        else $error("result without matching input transfer");

    a_zero_z: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_kind == KIND_ZERO_Z) |-> (o_potential == 29'sd0))
        else $error("zero valence result not zero");

endmodule

[src/nrp_log2.sv]
// pipelined base-2 logarithm in Q.24 by repeated squaring, one bit per stage
module nrp_log2 (
    input  logic                     i_clk,
    input  logic [30:0]              i_x,
    output logic [nrp_pkg::LOG_W-1:0] o_log
);
    import nrp_pkg::*;

    logic [31:0]      r_m  [0:STEPS];
    logic [LOG_W-1:0] r_lg [0:STEPS];
    logic [4:0]       n_p;
    logic [31:0]      n_m;

    // top set bit and normalized mantissa
    always_comb begin
        n_p = '0;
        for (int k = 0; k < 31; k++) begin
            if (i_x[k]) begin
                n_p = 5'(k);
            end
        end
        n_m = {1'b0, i_x} << (5'd31 - n_p);
    end

    always_ff @(posedge i_clk) begin
        r_m[0]  <= n_m;
        r_lg[0] <= {n_p, {FRAC_W{1'b0}}};
    end

    // one squaring per stage gives one fraction bit
    for (genvar g = 0; g < STEPS; g++) begin : g_step
        logic [63:0] sq;
        logic [32:0] sh;
        assign sq = {32'b0, r_m[g]} * {32'b0, r_m[g]};
        assign sh = sq[63:31];
        always_ff @(posedge i_clk) begin
            if (sh[32]) begin
                r_m[g+1]  <= sh[32:1];
                r_lg[g+1] <= r_lg[g] | (LOG_W'(1) << (FRAC_W - 1 - g));
            end else begin
                r_m[g+1]  <= sh[31:0];
                r_lg[g+1] <= r_lg[g];
            end
        end
    end

    assign o_log = r_lg[STEPS];

endmodule

[src/nrp_divz.sv]
// three stage divide by a small integer 1..16 through a reciprocal table
module nrp_divz (
    input  logic                   i_clk,
    input  logic [nrp_pkg::Y_W-1:0] i_y,
    input  logic [4:0]             i_zmag,
    output logic [nrp_pkg::Y_W-1:0] o_q
);
    import nrp_pkg::*;

    // floor(2^24 / z)
    function automatic logic [24:0] recip(input logic [4:0] z);
        logic [24:0] r;
        case (z)
            5'd1:    r = 25'd16777216;
            5'd2:    r = 25'd8388608;
            5'd3:    r = 25'd5592405;
            5'd4:    r = 25'd4194304;
            5'd5:    r = 25'd3355443;
            5'd6:    r = 25'd2796202;
            5'd7:    r = 25'd2396745;
            5'd8:    r = 25'd2097152;
            5'd9:    r = 25'd1864135;
            5'd10:   r = 25'd1677721;
            5'd11:   r = 25'd1525201;
            5'd12:   r = 25'd1398101;
            5'd13:   r = 25'd1290555;
            5'd14:   r = 25'd1198372;
            5'd15:   r = 25'd1118481;
            5'd16:   r = 25'd1048576;
            default: r = 25'd0;
        endcase
        return r;
    endfunction

    logic [43:0]    r_prod;
    logic [Y_W-1:0] r_y1;
    logic [4:0]     r_z1;
    logic [Y_W-1:0] r_q0;
    logic [5:0]     r_rem;
    logic [4:0]     r_z2;
    logic [Y_W-1:0] r_q;
    logic [Y_W-1:0] q0;
    logic [23:0]    qz;
    logic [23:0]    diff;

    // estimate is exact or one low
    assign q0   = r_prod[42:24];
    assign qz   = {5'b0, q0} * {19'b0, r_z1};
    assign diff = {5'b0, r_y1} - qz;

    always_ff @(posedge i_clk) begin
        r_prod <= {25'b0, i_y} * {19'b0, recip(i_zmag)};
        r_y1   <= i_y;
        r_z1   <= i_zmag;
        r_q0   <= q0;
        r_rem  <= diff[5:0];
        r_z2   <= r_z1;
        r_q    <= (r_rem >= {1'b0, r_z2}) ? r_q0 + 1'b1 : r_q0;
    end

    assign o_q = r_q;

endmodule
